@@ design/fpl_pkg.sv @@
`timescale 1ns / 1ps

package fpl_pkg;

    // cursor values and moves
    localparam logic [7:0] CURSOR_START = 8'd56;
    localparam logic [7:0] CURSOR_OFF   = 8'd255;
    localparam logic [7:0] RANK_BACK    = 8'd16;

    // characters with a meaning of their own
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_EIGHT = 8'h38;
    localparam logic [7:0] CH_W_LO  = 8'h77;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_K_UP  = 8'h4B;
    localparam logic [7:0] CH_Q_UP  = 8'h51;
    localparam logic [7:0] CH_K_LO  = 8'h6B;
    localparam logic [7:0] CH_Q_LO  = 8'h71;

    // piece codes
    localparam logic [2:0] PIECE_NONE   = 3'd0;
    localparam logic [2:0] PIECE_PAWN   = 3'd1;
    localparam logic [2:0] PIECE_KNIGHT = 3'd2;
    localparam logic [2:0] PIECE_BISHOP = 3'd3;
    localparam logic [2:0] PIECE_ROOK   = 3'd4;
    localparam logic [2:0] PIECE_QUEEN  = 3'd5;
    localparam logic [2:0] PIECE_KING   = 3'd6;

    // castling flag bits
    localparam int CASTLE_WK = 0;
    localparam int CASTLE_WQ = 1;
    localparam int CASTLE_BK = 2;
    localparam int CASTLE_BQ = 3;

    // width of the packed result payload
    localparam int RES_W = 10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ
    } fpl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;       // input transfer this cycle
        logic fill;       // one empty-square write of a digit run
        logic show_read;  // load registered square into result
    } fpl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_read;  // current input is a square read
        logic fill_start; // current character starts a digit run
        logic fill_last;  // last square of the digit run
    } fpl_stat_t;

    // color in bit 3, piece in bits 2..0, empty for anything else
    function automatic logic [3:0] letter_code(input logic [7:0] c);
        logic [3:0] code;
        code = {1'b0, PIECE_NONE};
        case (c)
            8'h50: code = {1'b0, PIECE_PAWN};
            8'h4E: code = {1'b0, PIECE_KNIGHT};
            8'h42: code = {1'b0, PIECE_BISHOP};
            8'h52: code = {1'b0, PIECE_ROOK};
            8'h51: code = {1'b0, PIECE_QUEEN};
            8'h4B: code = {1'b0, PIECE_KING};
            8'h70: code = {1'b1, PIECE_PAWN};
            8'h6E: code = {1'b1, PIECE_KNIGHT};
            8'h62: code = {1'b1, PIECE_BISHOP};
            8'h72: code = {1'b1, PIECE_ROOK};
            8'h71: code = {1'b1, PIECE_QUEEN};
            8'h6B: code = {1'b1, PIECE_KING};
            default: code = {1'b0, PIECE_NONE};
        endcase
        return code;
    endfunction

endpackage

@@ design/fen_position_loader_core.sv @@
`timescale 1ns / 1ps
// a parse transfer shows its result the next cycle; a square read passes the read registers
// and then the result register; a new letter, slash or space is taken while the result drains;
// a read or a digit run holds off input; one board write per square, single store write port
// reset: synchronous active-low aresetn empties the board, cursor to square 56,
// clears turn, castling flags and the stop flag; no clearing pass is needed

module fen_position_loader_core
    import fpl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] ch, [13:8] square, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [0] kind, [1] first
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] accepted, [3:1] square_piece, [4] square_color,
                                        // [5] turn, [6] castle_white_king,
                                        // [7] castle_white_queen, [8] castle_black_king,
                                        // [9] castle_black_queen, [15:10] zero
);

    fpl_cmd_t         cmd;
    fpl_stat_t        stat;
    logic [RES_W-1:0] res_data;

    // controller: sequencing, input ready and the result valid flag
    fpl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: character decode, cursor, board store and result register
    fpl_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_kind   (s_axis_tuser[0]),
        .in_ch     (s_axis_tdata[7:0]),
        .in_first  (s_axis_tuser[1]),
        .in_square (s_axis_tdata[13:8]),
        .cmd       (cmd),
        .stat      (stat),
        .res_data  (res_data)
    );

    // the result register parts the two sides; unused top bits read zero
    assign m_axis_tdata = {{(16 - RES_W){1'b0}}, res_data};

endmodule

@@ design/fpl_ctrl.sv @@
`timescale 1ns / 1ps

module fpl_ctrl
    import fpl_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  fpl_stat_t stat,
    output fpl_cmd_t  cmd
);

    fpl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        s_ready    = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
        take       = s_valid && s_ready;
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.take = take;
                if (take && stat.item_read) begin
                    state_next = ST_READ;
                end else if (take && stat.fill_start) begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (stat.fill_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.show_read = 1'b1;
                state_next    = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase

        // parse results load at the transfer, read results in the cycle after it
        if ((cmd.take && !stat.item_read) || cmd.show_read) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

@@ design/fpl_datapath.sv @@
`timescale 1ns / 1ps

module fpl_datapath
    import fpl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_kind,
    input  logic [7:0]       in_ch,
    input  logic             in_first,
    input  logic [5:0]       in_square,
    input  fpl_cmd_t         cmd,
    output fpl_stat_t        stat,
    output logic [RES_W-1:0] res_data
);

    // board: piece and color kept apart so a digit leaves color untouched
    logic [2:0]  piece_mem [64];
    logic        color_mem [64];
    logic [63:0] piece_vld_reg;
    logic [63:0] color_vld_reg;

    logic [7:0] cursor_reg, cursor_next;
    logic       stopped_reg, stopped_next;
    logic       turn_reg, turn_next;
    logic [3:0] castle_reg, castle_next;

    logic [6:0] fill_addr_reg;
    logic [3:0] fill_left_reg;

    logic [2:0] rd_piece_reg;
    logic       rd_color_reg;
    logic       rd_pvld_reg;
    logic       rd_cvld_reg;

    logic [RES_W-1:0] res_reg;

    logic [7:0] cur_eff;
    logic       stop_eff;
    logic       acc;
    logic       letter_wr;
    logic       fill_start;
    logic [3:0] run_len;
    logic [3:0] code;

    logic       wr_en;
    logic       wr_color_en;
    logic [5:0] wr_addr;
    logic [2:0] wr_piece;
    logic       parse_take;

    // character decode
    always_comb begin
        cur_eff      = in_first ? CURSOR_START : cursor_reg;
        stop_eff     = in_first ? 1'b0 : stopped_reg;
        cursor_next  = cur_eff;
        stopped_next = stop_eff;
        turn_next    = turn_reg;
        castle_next  = castle_reg;
        acc          = 1'b0;
        letter_wr    = 1'b0;
        fill_start   = 1'b0;
        run_len      = in_ch[3:0];
        code         = letter_code(in_ch);
        if (!stop_eff) begin
            acc = 1'b1;
            if (in_ch == CH_SPACE) begin
                cursor_next = CURSOR_OFF;
            end else if (in_ch == CH_SLASH) begin
                if (cur_eff == CURSOR_OFF || cur_eff < RANK_BACK) begin
                    cursor_next = CURSOR_OFF;
                end else begin
                    cursor_next = cur_eff - RANK_BACK;
                end
            end else if (cur_eff[7:6] == 2'b00) begin
                if (in_ch >= CH_ONE && in_ch <= CH_EIGHT) begin
                    fill_start  = 1'b1;
                    cursor_next = cur_eff + {4'b0, run_len};
                end else begin
                    letter_wr   = 1'b1;
                    cursor_next = cur_eff + 8'd1;
                end
            end else begin
                case (in_ch)
                    CH_W_LO: turn_next = 1'b0;
                    CH_B_LO: turn_next = 1'b1;
                    CH_K_UP: castle_next[CASTLE_WK] = 1'b1;
                    CH_Q_UP: castle_next[CASTLE_WQ] = 1'b1;
                    CH_K_LO: castle_next[CASTLE_BK] = 1'b1;
                    CH_Q_LO: castle_next[CASTLE_BQ] = 1'b1;
                    default: begin
                        acc          = 1'b0;
                        stopped_next = 1'b1;
                    end
                endcase
            end
        end
    end

    assign parse_take      = cmd.take && !in_kind;
    assign stat.item_read  = in_kind;
    assign stat.fill_start = fill_start;
    assign stat.fill_last  = (fill_left_reg == 4'd1);

    // one write port: letter at the transfer or one square of a digit run
    always_comb begin
        wr_en       = 1'b0;
        wr_color_en = 1'b0;
        wr_addr     = cur_eff[5:0];
        wr_piece    = code[2:0];
        if (cmd.fill) begin
            wr_en    = !fill_addr_reg[6];
            wr_addr  = fill_addr_reg[5:0];
            wr_piece = PIECE_NONE;
        end else if (parse_take && letter_wr) begin
            wr_en       = 1'b1;
            wr_color_en = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            piece_mem[wr_addr] <= wr_piece;
        end
        if (wr_color_en) begin
            color_mem[wr_addr] <= code[3];
        end
        if (cmd.take && in_kind) begin
            rd_piece_reg <= piece_mem[in_square];
            rd_color_reg <= color_mem[in_square];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            piece_vld_reg <= '0;
            color_vld_reg <= '0;
            cursor_reg    <= CURSOR_START;
            stopped_reg   <= 1'b0;
            turn_reg      <= 1'b0;
            castle_reg    <= '0;
            fill_left_reg <= '0;
        end else begin
            if (wr_en) begin
                piece_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr_color_en) begin
                color_vld_reg[wr_addr] <= 1'b1;
            end
            if (parse_take) begin
                cursor_reg  <= cursor_next;
                stopped_reg <= stopped_next;
                turn_reg    <= turn_next;
                castle_reg  <= castle_next;
            end
            if (parse_take && fill_start) begin
                fill_left_reg <= run_len;
            end else if (cmd.fill) begin
                fill_left_reg <= fill_left_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (parse_take && fill_start) begin
            fill_addr_reg <= cur_eff[6:0];
        end else if (cmd.fill) begin
            fill_addr_reg <= fill_addr_reg + 7'd1;
        end
        if (cmd.take && in_kind) begin
            rd_pvld_reg <= piece_vld_reg[in_square];
            rd_cvld_reg <= color_vld_reg[in_square];
        end
        if (parse_take) begin
            res_reg <= {castle_next, turn_next, 1'b0, PIECE_NONE, acc};
        end else if (cmd.show_read) begin
            res_reg <= {castle_reg, turn_reg,
                        rd_cvld_reg ? rd_color_reg : 1'b0,
                        rd_pvld_reg ? rd_piece_reg : PIECE_NONE,
                        1'b0};
        end
    end

    assign res_data = res_reg;

endmodule

@@ design/fpl_checker.sv @@
`timescale 1ns / 1ps

module fpl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no result after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an input transfer only when the result slot is free or draining
    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
        else $error("input taken with result slot blocked");

    // piece code seven never appears
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[3:1] != 3'd7)
        else $error("illegal piece code");

    // a square read never reports a consumed character
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[3:1] != 3'd0 || m_axis_tdata[4]) |->
            !m_axis_tdata[0])
        else $error("read result marked accepted");

endmodule

bind fen_position_loader_core fpl_checker u_fpl_checker (.*);
